// File: design/idst_pkg.sv
// Shared types, request and status codes for the id slot table.
`timescale 1ns / 1ps
`default_nettype none

package idst_pkg;

	// default table depth
	localparam int DEPTH_DEF = 64;

	// port field widths
	localparam int ID_W  = 32;
	localparam int IDX_W = 6;

	typedef logic [1:0]       kind_t;
	typedef logic [1:0]       status_t;
	typedef logic [ID_W-1:0]  id_t;
	typedef logic [IDX_W-1:0] idx_t;

	// request kinds
	localparam kind_t KIND_APPEND   = 2'd0;
	localparam kind_t KIND_ADD_ZERO = 2'd1;
	localparam kind_t KIND_REPLACE  = 2'd2;
	localparam kind_t KIND_FIND     = 2'd3;

	// result status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_RANGE     = 2'd3;

endpackage

`default_nettype wire

// File: design/id_slot_table_with_zero_reuse.sv
// Id slot table with zero reuse: a fill-from-zero table of 32-bit ids.
//
// Usage: drive kind, id_value and slot_index with start high; the request
// word is taken at a rising edge where start is high and busy is low.
// busy stays high while the request is worked on. Exactly one result word
// (result_index, status) follows, shown for one cycle with done high; the
// receiver cannot stall it, and a new request may be taken in that cycle.
// Append and replace resolve in the exec state, from which done is registered. Find and
// add-reusing-zero walk the filled slots through the table memory's single
// registered read port, one slot per cycle; the first hit ends the scan, and a
// full miss ends it once every filled slot has been read and compared. A miss on
// add-reusing-zero then appends in the same cycle.
// Reset clears the fill count and the sequencer; slot contents are not
// cleared, since only slots below the fill count are ever read.
// result_index carries the low 6 bits of the slot number.
`timescale 1ns / 1ps
`default_nettype none

module id_slot_table_with_zero_reuse #(
	parameter int TABLE_DEPTH = idst_pkg::DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  idst_pkg::kind_t      kind,
	input  idst_pkg::id_t        id_value,
	input  idst_pkg::idx_t       slot_index,
	output logic                 done,
	output idst_pkg::idx_t       result_index,
	output idst_pkg::status_t    status
);
	import idst_pkg::*;

	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN} state_t;

	state_t          state_q;
	kind_t           kind_q;
	id_t             id_q;
	idx_t            slot_q;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   ptr_q;
	logic            rvalid_q;
	logic [AW-1:0]   ridx_q;
	id_t             rdata_q;

	id_t             mem [TABLE_DEPTH];

	logic            mem_we;
	logic [AW-1:0]   waddr;
	logic            fill_inc;
	logic            fin;
	logic [CMPW-1:0] fin_idx;
	status_t         fin_st;
	logic            full;
	logic            ptr_live;
	logic [CMPW-1:0] slot_ext;
	logic [CMPW-1:0] fill_ext;
	id_t             target;
	logic            hit;

	assign busy     = (state_q != S_IDLE);
	assign full     = (fill_q == CW'(TABLE_DEPTH));
	assign ptr_live = (ptr_q < fill_q);
	assign slot_ext = CMPW'(slot_q);
	assign fill_ext = CMPW'(fill_q);
	assign target   = (kind_q == KIND_ADD_ZERO) ? '0 : id_q;
	assign hit      = rvalid_q && (rdata_q == target);

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= id_q;
		end
		rdata_q <= mem[ptr_q[AW-1:0]];
	end

	// request resolution: write decision and result word
	always_comb begin
		mem_we   = 1'b0;
		waddr    = fill_q[AW-1:0];
		fill_inc = 1'b0;
		fin      = 1'b0;
		fin_idx  = '0;
		fin_st   = ST_OK;
		case (state_q)
			S_EXEC: begin
				fin = 1'b1;
				case (kind_q)
					KIND_REPLACE: begin
						if (slot_ext < fill_ext) begin
							mem_we  = 1'b1;
							waddr   = slot_ext[AW-1:0];
							fin_idx = slot_ext;
						end else begin
							fin_st = ST_RANGE;
						end
					end
					default: begin
						if (!full) begin
							mem_we   = 1'b1;
							fill_inc = 1'b1;
							fin_idx  = fill_ext;
						end else begin
							fin_st = ST_FULL;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (hit) begin
					fin     = 1'b1;
					fin_idx = CMPW'(ridx_q);
					if (kind_q == KIND_ADD_ZERO) begin
						mem_we = 1'b1;
						waddr  = ridx_q;
					end
				end else if (!rvalid_q && !ptr_live) begin
					fin = 1'b1;
					if (kind_q == KIND_FIND) begin
						fin_st = ST_NOT_FOUND;
					end else if (!full) begin
						// no free slot: append instead
						mem_we   = 1'b1;
						fill_inc = 1'b1;
						fin_idx  = fill_ext;
					end else begin
						fin_st = ST_FULL;
					end
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// sequencer, scan pointer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			ptr_q        <= '0;
			rvalid_q     <= 1'b0;
			done         <= 1'b0;
			kind_q       <= KIND_APPEND;
			id_q         <= '0;
			slot_q       <= '0;
			ridx_q       <= '0;
			result_index <= '0;
			status       <= ST_OK;
		end else begin
			done <= fin;
			if (fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q   <= kind;
						id_q     <= id_value;
						slot_q   <= slot_index;
						ptr_q    <= '0;
						rvalid_q <= 1'b0;
						if (kind inside {KIND_ADD_ZERO, KIND_FIND}) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_SCAN: begin
					// issue next slot read while comparing the previous one
					rvalid_q <= ptr_live;
					ridx_q   <= ptr_q[AW-1:0];
					if (ptr_live) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (fin) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fin) begin
				result_index <= fin_idx[IDX_W-1:0];
				status       <= fin_st;
			end
		end
	end

`ifndef ASSERT_OFF
	// a result only follows a request in progress
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != S_IDLE))
		else $error("result without request");

	// fill count never passes the depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond depth");

	// fill count grows by at most one, and only when a result is produced
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (done && fill_q == $past(fill_q) + 1'b1))
		else $error("bad fill count step");

	// the table is written only while a request is in progress
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("table write while idle");
`endif

endmodule

`default_nettype wire
